// ===== src/awcr_pkg.sv =====
package awcr_pkg;

   localparam int LANES         = 8;
   localparam int BYTE_BITS     = 8;
   localparam int OFFSET_BITS   = 24;
   localparam int REACH_BITS    = 16;
   localparam int COUNT_BITS    = 17;
   localparam int SCOUNT_BITS   = 4;
   localparam int LANE_IDX_BITS = $clog2(LANES);
   localparam int LANE_CNT_BITS = $clog2(LANES + 1);
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 17;

   localparam logic [REACH_BITS-1:0]  REACH_RESET        = REACH_BITS'(10000);
   localparam logic [SCOUNT_BITS-1:0] SAMPLE_COUNT_RESET = SCOUNT_BITS'(2);
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX          = '1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SAMPLE_COUNT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOWER_BOUND  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REACH        = 2'd2;

   localparam logic CMD_DESCRIPTOR = 1'b0;
   localparam logic CMD_COLUMN     = 1'b1;

   localparam logic KIND_WINDOW = 1'b0;
   localparam logic KIND_MATCH  = 1'b1;

   typedef struct packed {
      logic step;
      logic clear;
   } run_ctrl_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] best_begin;
      logic [COUNT_BITS-1:0] best_size;
   } run_status_type;

endpackage

// ===== src/awcr_lane.sv =====
module awcr_lane (
   input  logic [awcr_pkg::BYTE_BITS-1:0] lane_byte,
   input  logic [awcr_pkg::BYTE_BITS-1:0] ref_byte,
   input  logic                           lane_mask,
   input  logic                           lane_used,
   output logic                           lane_ok
);
   import awcr_pkg::*;

   // unused lanes never veto a column
   assign lane_ok = !lane_used || ((lane_byte == ref_byte) && !lane_mask);

endmodule

// ===== src/awcr_run.sv =====
module awcr_run (
   input  logic                           clock,
   input  logic                           reset,
   input  awcr_pkg::run_ctrl_type         ctrl,
   input  logic [awcr_pkg::LANES-1:0]     lane_ok,
   output awcr_pkg::run_status_type       status
);
   import awcr_pkg::*;

   logic                  col_match;
   logic [COUNT_BITS-1:0] col_count_ff,  col_count_in;
   logic [COUNT_BITS-1:0] run_begin_ff,  run_begin_in;
   logic [COUNT_BITS-1:0] run_size_ff,   run_size_in;
   logic [COUNT_BITS-1:0] best_begin_ff, best_begin_in;
   logic [COUNT_BITS-1:0] best_size_ff,  best_size_in;

   assign col_match = &lane_ok;

   always_comb begin
      col_count_in  = col_count_ff;
      run_begin_in  = run_begin_ff;
      run_size_in   = run_size_ff;
      best_begin_in = best_begin_ff;
      best_size_in  = best_size_ff;
      if (ctrl.step) begin
         if (col_match) begin
            if (run_size_ff == '0) begin
               run_begin_in = col_count_ff;
            end
            if (run_size_ff != COUNT_MAX) begin
               run_size_in = run_size_ff + COUNT_BITS'(1);
            end
            // strict compare keeps the earliest of equal runs
            if (run_size_in > best_size_ff) begin
               best_size_in  = run_size_in;
               best_begin_in = run_begin_in;
            end
         end else begin
            run_size_in = '0;
         end
         if (col_count_ff != COUNT_MAX) begin
            col_count_in = col_count_ff + COUNT_BITS'(1);
         end
      end
   end

   assign status.best_begin = best_begin_in;
   assign status.best_size  = best_size_in;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         col_count_ff  <= '0;
         run_begin_ff  <= '0;
         run_size_ff   <= '0;
         best_begin_ff <= '0;
         best_size_ff  <= '0;
      end else begin
         col_count_ff  <= col_count_in;
         run_begin_ff  <= run_begin_in;
         run_size_ff   <= run_size_in;
         best_begin_ff <= best_begin_in;
         best_size_ff  <= best_size_in;
      end
   end

endmodule

// ===== src/aligned_window_common_run_core.sv =====
// Longest common run finder over up to eight aligned byte samples. Send one
// descriptor item per sample (length and suggested start); each returns one
// window report with the shared extent before and after the anchors. Then send
// one column item per aligned position; a column matches when every lane in use
// carries lane 0's byte and no mask bit in use is set. Descriptors and columns
// without last_column are taken one per cycle, limited only by the output
// register: the eight lane comparators and the run tracker's update logic are
// combinational. On the last column the block emits one not-worked result, or
// one result per lane in use, one per cycle while rsp_stall is low once the
// sequencer is loaded; the input stalls meanwhile. The search state then clears;
// anchors are kept. Write registers only while the block is idle.
module aligned_window_common_run_core (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   csr_we,
   input  logic [awcr_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [awcr_pkg::CSR_DATA_BITS-1:0]     csr_wdata,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_cmd,
   input  logic [2:0]                             req_sample_index,
   input  logic [awcr_pkg::OFFSET_BITS-1:0]       req_sample_length,
   input  logic [awcr_pkg::OFFSET_BITS-1:0]       req_start_hint,
   input  logic [awcr_pkg::LANES*awcr_pkg::BYTE_BITS-1:0] req_column_bytes,
   input  logic [awcr_pkg::LANES-1:0]             req_column_masks,
   input  logic                                   req_last_column,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_kind,
   output logic [awcr_pkg::REACH_BITS-1:0]        rsp_window_before,
   output logic [awcr_pkg::REACH_BITS-1:0]        rsp_window_after,
   output logic [2:0]                             rsp_result_sample,
   output logic [awcr_pkg::OFFSET_BITS-1:0]       rsp_match_position,
   output logic [awcr_pkg::COUNT_BITS-1:0]        rsp_match_length,
   output logic                                   rsp_worked,
   output logic                                   rsp_last_result
);
   import awcr_pkg::*;

   // registers
   logic [SCOUNT_BITS-1:0] sample_count_ff;
   logic [COUNT_BITS-1:0]  lower_bound_ff;
   logic [REACH_BITS-1:0]  reach_ff;
   logic [REACH_BITS-1:0]  extent_before_ff, extent_before_in;
   logic [REACH_BITS-1:0]  extent_after_ff,  extent_after_in;
   logic [OFFSET_BITS-1:0] anchor_ff [LANES];

   // result sequencer
   logic                     emit_active_ff, emit_active_in;
   logic [LANE_IDX_BITS-1:0] emit_idx_ff,    emit_idx_in;
   logic [LANE_CNT_BITS-1:0] emit_n_ff,      emit_n_in;
   logic [REACH_BITS-1:0]    emit_before_ff, emit_before_in;
   logic [REACH_BITS-1:0]    emit_after_ff,  emit_after_in;
   logic [COUNT_BITS-1:0]    emit_begin_ff,  emit_begin_in;
   logic [COUNT_BITS-1:0]    emit_size_ff,   emit_size_in;

   // output register
   logic                   rsp_valid_ff,    rsp_valid_in;
   logic                   rsp_kind_ff,     rsp_kind_in;
   logic [REACH_BITS-1:0]  rsp_before_ff,   rsp_before_in;
   logic [REACH_BITS-1:0]  rsp_after_ff,    rsp_after_in;
   logic [2:0]             rsp_sample_ff,   rsp_sample_in;
   logic [OFFSET_BITS-1:0] rsp_position_ff, rsp_position_in;
   logic [COUNT_BITS-1:0]  rsp_length_ff,   rsp_length_in;
   logic                   rsp_worked_ff,   rsp_worked_in;
   logic                   rsp_last_ff,     rsp_last_in;

   logic                     out_free;
   logic                     accept;
   logic                     take_desc;
   logic                     take_last;
   logic [LANE_CNT_BITS-1:0] lanes_n;
   logic [LANES-1:0]         lane_used;
   logic [LANES-1:0]         lane_ok;
   run_ctrl_type             run_ctrl;
   run_status_type           run_status;

   logic [OFFSET_BITS-1:0]   start_fix;
   logic [OFFSET_BITS-1:0]   after_raw;
   logic [OFFSET_BITS-1:0]   reach_wide;
   logic [REACH_BITS-1:0]    desc_before;
   logic [REACH_BITS-1:0]    desc_after;
   logic [OFFSET_BITS-1:0]   emit_position;
   logic                     emit_final;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = emit_active_ff || !out_free;
   assign accept    = req_valid && !req_stall;
   assign take_desc = accept && (req_cmd == CMD_DESCRIPTOR);
   assign take_last = accept && (req_cmd == CMD_COLUMN) && req_last_column;

   always_comb begin
      if (sample_count_ff == '0) begin
         lanes_n = LANE_CNT_BITS'(1);
      end else if (sample_count_ff > SCOUNT_BITS'(LANES)) begin
         lanes_n = LANE_CNT_BITS'(LANES);
      end else begin
         lanes_n = LANE_CNT_BITS'(sample_count_ff);
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      assign lane_used[i] = LANE_CNT_BITS'(i) < lanes_n;
      awcr_lane u_lane (
         .lane_byte (req_column_bytes[i*BYTE_BITS +: BYTE_BITS]),
         .ref_byte  (req_column_bytes[BYTE_BITS-1:0]),
         .lane_mask (req_column_masks[i]),
         .lane_used (lane_used[i]),
         .lane_ok   (lane_ok[i])
      );
   end

   assign run_ctrl.step  = accept && (req_cmd == CMD_COLUMN);
   assign run_ctrl.clear = take_last;

   awcr_run u_run (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (run_ctrl),
      .lane_ok (lane_ok),
      .status  (run_status)
   );

   // descriptor window arithmetic
   assign reach_wide = OFFSET_BITS'(reach_ff);
   assign start_fix  = (req_start_hint >= req_sample_length) ? '0 : req_start_hint;
   assign after_raw  = (req_sample_length == '0) ? '0 :
                       req_sample_length - OFFSET_BITS'(1) - start_fix;
   assign desc_before = (start_fix > reach_wide) ? reach_ff : start_fix[REACH_BITS-1:0];
   assign desc_after  = (after_raw > reach_wide) ? reach_ff : after_raw[REACH_BITS-1:0];

   assign emit_position = anchor_ff[emit_idx_ff] - OFFSET_BITS'(emit_before_ff)
                          + OFFSET_BITS'(emit_begin_ff);
   assign emit_final    = (LANE_CNT_BITS'(emit_idx_ff) + LANE_CNT_BITS'(1)) == emit_n_ff;

   always_comb begin
      extent_before_in = extent_before_ff;
      extent_after_in  = extent_after_ff;
      emit_active_in   = emit_active_ff;
      emit_idx_in      = emit_idx_ff;
      emit_n_in        = emit_n_ff;
      emit_before_in   = emit_before_ff;
      emit_after_in    = emit_after_ff;
      emit_begin_in    = emit_begin_ff;
      emit_size_in     = emit_size_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_kind_in      = rsp_kind_ff;
      rsp_before_in    = rsp_before_ff;
      rsp_after_in     = rsp_after_ff;
      rsp_sample_in    = rsp_sample_ff;
      rsp_position_in  = rsp_position_ff;
      rsp_length_in    = rsp_length_ff;
      rsp_worked_in    = rsp_worked_ff;
      rsp_last_in      = rsp_last_ff;

      if (emit_active_ff && out_free) begin
         rsp_valid_in    = 1'b1;
         rsp_kind_in     = KIND_MATCH;
         rsp_before_in   = emit_before_ff;
         rsp_after_in    = emit_after_ff;
         rsp_sample_in   = 3'(emit_idx_ff);
         rsp_position_in = emit_position;
         rsp_length_in   = emit_size_ff;
         rsp_worked_in   = 1'b1;
         rsp_last_in     = emit_final;
         emit_idx_in     = emit_idx_ff + LANE_IDX_BITS'(1);
         if (emit_final) begin
            emit_active_in = 1'b0;
         end
      end

      if (take_desc) begin
         if (desc_before < extent_before_ff) begin
            extent_before_in = desc_before;
         end
         if (desc_after < extent_after_ff) begin
            extent_after_in = desc_after;
         end
         rsp_valid_in    = 1'b1;
         rsp_kind_in     = KIND_WINDOW;
         rsp_before_in   = extent_before_in;
         rsp_after_in    = extent_after_in;
         rsp_sample_in   = '0;
         rsp_position_in = '0;
         rsp_length_in   = '0;
         rsp_worked_in   = 1'b0;
         rsp_last_in     = 1'b1;
      end

      if (take_last) begin
         if (run_status.best_size > lower_bound_ff) begin
            emit_active_in = 1'b1;
            emit_idx_in    = '0;
            emit_n_in      = lanes_n;
            emit_before_in = extent_before_ff;
            emit_after_in  = extent_after_ff;
            emit_begin_in  = run_status.best_begin;
            emit_size_in   = run_status.best_size;
         end else begin
            rsp_valid_in    = 1'b1;
            rsp_kind_in     = KIND_MATCH;
            rsp_before_in   = extent_before_ff;
            rsp_after_in    = extent_after_ff;
            rsp_sample_in   = '0;
            rsp_position_in = '0;
            rsp_length_in   = '0;
            rsp_worked_in   = 1'b0;
            rsp_last_in     = 1'b1;
         end
         extent_before_in = reach_ff;
         extent_after_in  = reach_ff;
      end

      if (csr_we && (csr_index == CSR_REACH)) begin
         extent_before_in = csr_wdata[REACH_BITS-1:0];
         extent_after_in  = csr_wdata[REACH_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff  <= SAMPLE_COUNT_RESET;
         lower_bound_ff   <= '0;
         reach_ff         <= REACH_RESET;
         extent_before_ff <= REACH_RESET;
         extent_after_ff  <= REACH_RESET;
         emit_active_ff   <= 1'b0;
         emit_idx_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[SCOUNT_BITS-1:0];
               CSR_LOWER_BOUND:  lower_bound_ff  <= csr_wdata[COUNT_BITS-1:0];
               CSR_REACH:        reach_ff        <= csr_wdata[REACH_BITS-1:0];
               default: ;
            endcase
         end
         extent_before_ff <= extent_before_in;
         extent_after_ff  <= extent_after_in;
         emit_active_ff   <= emit_active_in;
         emit_idx_ff      <= emit_idx_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_desc) begin
         anchor_ff[req_sample_index[LANE_IDX_BITS-1:0]] <= start_fix;
      end
      emit_n_ff       <= emit_n_in;
      emit_before_ff  <= emit_before_in;
      emit_after_ff   <= emit_after_in;
      emit_begin_ff   <= emit_begin_in;
      emit_size_ff    <= emit_size_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_before_ff   <= rsp_before_in;
      rsp_after_ff    <= rsp_after_in;
      rsp_sample_ff   <= rsp_sample_in;
      rsp_position_ff <= rsp_position_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_worked_ff   <= rsp_worked_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_window_before  = rsp_before_ff;
   assign rsp_window_after   = rsp_after_ff;
   assign rsp_result_sample  = rsp_sample_ff;
   assign rsp_match_position = rsp_position_ff;
   assign rsp_match_length   = rsp_length_ff;
   assign rsp_worked         = rsp_worked_ff;
   assign rsp_last_result    = rsp_last_ff;

endmodule

// ===== test/awcr_check_pkg.sv =====
`timescale 1ns / 100ps
package awcr_check_pkg;
   import awcr_pkg::*;

   typedef struct packed {
      logic                        cmd;
      logic [LANE_IDX_BITS-1:0]    sample_index;
      logic [OFFSET_BITS-1:0]      sample_length;
      logic [OFFSET_BITS-1:0]      start_hint;
      logic [LANES*BYTE_BITS-1:0]  column_bytes;
      logic [LANES-1:0]            column_masks;
      logic                        last_column;
   } awcr_item_type;

   typedef struct packed {
      logic                        kind;
      logic [REACH_BITS-1:0]       window_before;
      logic [REACH_BITS-1:0]       window_after;
      logic [LANE_IDX_BITS-1:0]    result_sample;
      logic [OFFSET_BITS-1:0]      match_position;
      logic [COUNT_BITS-1:0]       match_length;
      logic                        worked;
      logic                        last_result;
   } awcr_result_type;

   class common_run_predictor;
      logic [SCOUNT_BITS-1:0]  sample_count;
      logic [COUNT_BITS-1:0]   lower_bound;
      logic [REACH_BITS-1:0]   reach;
      logic [OFFSET_BITS-1:0]  anchors [LANES];
      logic [REACH_BITS-1:0]   extent_before;
      logic [REACH_BITS-1:0]   extent_after;
      logic [COUNT_BITS-1:0]   column_count;
      logic [COUNT_BITS-1:0]   run_begin;
      logic [COUNT_BITS-1:0]   run_size;
      logic [COUNT_BITS-1:0]   best_begin;
      logic [COUNT_BITS-1:0]   best_size;
      awcr_result_type         pending_results [$];
      int                      errors;
      int                      compared;
      int                      window_reports;
      int                      match_results;
      int                      empty_outcomes;

      function new();
         sample_count = SAMPLE_COUNT_RESET;
         lower_bound = '0;
         reach = REACH_RESET;
         foreach (anchors[i]) anchors[i] = '0;
         clear_search();
         errors = 0;
         compared = 0;
         window_reports = 0;
         match_results = 0;
         empty_outcomes = 0;
      endfunction

      function void clear_search();
         extent_before = reach;
         extent_after = reach;
         column_count = '0;
         run_begin = '0;
         run_size = '0;
         best_begin = '0;
         best_size = '0;
      endfunction

      function int lanes_used();
         int n;
         n = sample_count;
         if (n == 0) n = 1;
         if (n > LANES) n = LANES;
         if (n > 8) n = 8;
         return n;
      endfunction

      function void note_config(logic [CSR_IDX_BITS-1:0] idx,
                                logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_SAMPLE_COUNT: sample_count = value[SCOUNT_BITS-1:0];
            CSR_LOWER_BOUND: lower_bound = value[COUNT_BITS-1:0];
            CSR_REACH: begin
               reach = value[REACH_BITS-1:0];
               extent_before = reach;
               extent_after = reach;
            end
            default: ;
         endcase
      endfunction

      function void add_result(logic kind, logic [LANE_IDX_BITS-1:0] sample,
                               logic [OFFSET_BITS-1:0] pos, logic [COUNT_BITS-1:0] len,
                               logic worked, logic last);
         awcr_result_type r;
         r.kind = kind;
         r.window_before = extent_before;
         r.window_after = extent_after;
         r.result_sample = sample;
         r.match_position = pos;
         r.match_length = len;
         r.worked = worked;
         r.last_result = last;
         pending_results.push_back(r);
      endfunction

      function void note_item(awcr_item_type it);
         logic [OFFSET_BITS-1:0] len;
         logic [OFFSET_BITS-1:0] start;
         logic [OFFSET_BITS-1:0] lead;
         logic [OFFSET_BITS-1:0] after;
         logic [OFFSET_BITS-1:0] pos;
         logic [BYTE_BITS-1:0]   b0;
         logic                   hit;
         int                     n;

         if (it.cmd == CMD_DESCRIPTOR) begin
            len = it.sample_length;
            start = it.start_hint;
            if (start >= len) start = '0;
            anchors[it.sample_index] = start;
            lead = start;
            after = (len == 0) ? '0 : len - OFFSET_BITS'(1) - start;
            if (lead > OFFSET_BITS'(reach)) lead = OFFSET_BITS'(reach);
            if (after > OFFSET_BITS'(reach)) after = OFFSET_BITS'(reach);
            if (lead < OFFSET_BITS'(extent_before)) extent_before = lead[REACH_BITS-1:0];
            if (after < OFFSET_BITS'(extent_after)) extent_after = after[REACH_BITS-1:0];
            add_result(KIND_WINDOW, '0, '0, '0, 1'b0, 1'b1);
            window_reports++;
            return;
         end

         n = lanes_used();
         b0 = it.column_bytes[BYTE_BITS-1:0];
         hit = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (it.column_bytes[BYTE_BITS*i +: BYTE_BITS] != b0 || it.column_masks[i])
               hit = 1'b0;
         end
         if (hit) begin
            if (run_size == 0) run_begin = column_count;
            if (run_size != COUNT_MAX) run_size = run_size + COUNT_BITS'(1);
            if (run_size > best_size) begin
               best_size = run_size;
               best_begin = run_begin;
            end
         end else begin
            run_size = '0;
         end
         if (column_count != COUNT_MAX) column_count = column_count + COUNT_BITS'(1);
         if (!it.last_column) return;

         if (best_size > lower_bound) begin
            for (int i = 0; i < n; i++) begin
               pos = anchors[i] - OFFSET_BITS'(extent_before) + OFFSET_BITS'(best_begin);
               add_result(KIND_MATCH, LANE_IDX_BITS'(i), pos, best_size, 1'b1, i == n - 1);
               match_results++;
            end
         end else begin
            add_result(KIND_MATCH, '0, '0, '0, 1'b0, 1'b1);
            empty_outcomes++;
         end
         clear_search();
      endfunction

      function void compare(string field, longint unsigned want, longint unsigned got);
         if (want != got) begin
            if (errors < 10)
               $display("ERROR: result %0d field %s expected %0h got %0h",
                        compared, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(awcr_result_type got);
         awcr_result_type want;
         if (pending_results.size() == 0) begin
            if (errors < 10) $display("ERROR: result %h arrived with none pending", got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare("kind", want.kind, got.kind);
         compare("window_before", want.window_before, got.window_before);
         compare("window_after", want.window_after, got.window_after);
         compare("result_sample", want.result_sample, got.result_sample);
         compare("match_position", want.match_position, got.match_position);
         compare("match_length", want.match_length, got.match_length);
         compare("worked", want.worked, got.worked);
         compare("last_result", want.last_result, got.last_result);
         compared++;
      endfunction
   endclass

endpackage

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
   import awcr_pkg::*;
   import awcr_check_pkg::*;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 16;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_wdata = '0;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_cmd = 1'b0;
   logic [LANE_IDX_BITS-1:0]    req_sample_index = '0;
   logic [OFFSET_BITS-1:0]      req_sample_length = '0;
   logic [OFFSET_BITS-1:0]      req_start_hint = '0;
   logic [LANES*BYTE_BITS-1:0]  req_column_bytes = '0;
   logic [LANES-1:0]            req_column_masks = '0;
   logic                        req_last_column = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_kind;
   logic [REACH_BITS-1:0]       rsp_window_before;
   logic [REACH_BITS-1:0]       rsp_window_after;
   logic [LANE_IDX_BITS-1:0]    rsp_result_sample;
   logic [OFFSET_BITS-1:0]      rsp_match_position;
   logic [COUNT_BITS-1:0]       rsp_match_length;
   logic                        rsp_worked;
   logic                        rsp_last_result;

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  long_hold = 1'b0;
   int  hold_left = 0;
   int  cycles = 0;
   int  items_sent = 0;
   common_run_predictor runs = new();

   aligned_window_common_run_core DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_sample_index    (req_sample_index),
      .req_sample_length   (req_sample_length),
      .req_start_hint      (req_start_hint),
      .req_column_bytes    (req_column_bytes),
      .req_column_masks    (req_column_masks),
      .req_last_column     (req_last_column),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_window_before   (rsp_window_before),
      .rsp_window_after    (rsp_window_after),
      .rsp_result_sample   (rsp_result_sample),
      .rsp_match_position  (rsp_match_position),
      .rsp_match_length    (rsp_match_length),
      .rsp_worked          (rsp_worked),
      .rsp_last_result     (rsp_last_result)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver back-pressure; a long hold-off lets the block fill up
   always @(negedge clock) begin
      if (long_hold) begin
         hold_left = LONG_HOLD;
         long_hold = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         runs.check_result({rsp_kind, rsp_window_before, rsp_window_after, rsp_result_sample,
                            rsp_match_position, rsp_match_length, rsp_worked,
                            rsp_last_result});
   end

   function automatic awcr_item_type descriptor(input logic [LANE_IDX_BITS-1:0] idx,
                                                input logic [OFFSET_BITS-1:0] len,
                                                input logic [OFFSET_BITS-1:0] start);
      awcr_item_type it;
      it.cmd = CMD_DESCRIPTOR;
      it.sample_index = idx;
      it.sample_length = len;
      it.start_hint = start;
      it.column_bytes = {$urandom, $urandom};
      it.column_masks = 8'($urandom);
      it.last_column = 1'($urandom);
      return it;
   endfunction

   function automatic awcr_item_type column(input logic [LANES*BYTE_BITS-1:0] bytes,
                                            input logic [LANES-1:0] masks, input logic last);
      awcr_item_type it;
      it.cmd = CMD_COLUMN;
      it.sample_index = 3'($urandom);
      it.sample_length = 24'($urandom);
      it.start_hint = 24'($urandom);
      it.column_bytes = bytes;
      it.column_masks = masks;
      it.last_column = last;
      return it;
   endfunction

   // lanes in use agree unless hit is clear; idle lanes carry junk
   function automatic awcr_item_type random_column(input int lanes, input bit hit,
                                                   input logic last);
      logic [LANES*BYTE_BITS-1:0] bytes;
      logic [LANES-1:0]           masks;
      logic [BYTE_BITS-1:0]       b;
      int                         k;
      bytes = {$urandom, $urandom};
      masks = 8'($urandom);
      b = 8'($urandom);
      for (k = 0; k < lanes; k++) begin
         bytes[BYTE_BITS*k +: BYTE_BITS] = b;
         masks[k] = 1'b0;
      end
      if (!hit) begin
         k = $urandom_range(lanes - 1);
         if (lanes > 1 && $urandom_range(1))
            bytes[BYTE_BITS*k +: BYTE_BITS] = b ^ 8'($urandom_range(1, 255));
         else
            masks[k] = 1'b1;
      end
      return column(bytes, masks, last);
   endfunction

   function automatic awcr_item_type random_descriptor(input int lanes);
      logic [LANE_IDX_BITS-1:0] idx;
      logic [OFFSET_BITS-1:0]   len;
      logic [OFFSET_BITS-1:0]   start;
      idx = ($urandom_range(4) == 0) ? 3'($urandom) : 3'($urandom_range(lanes - 1));
      case ($urandom_range(3))
         0: len = 24'($urandom_range(40));
         1: len = 24'($urandom_range(70000));
         2: len = 24'($urandom);
         default: len = '1;
      endcase
      case ($urandom_range(3))
         0: start = 24'($urandom_range(len));
         1: start = 24'($urandom);
         2: start = len - 1'b1 - 24'($urandom_range(3));
         default: start = 24'($urandom_range(12000));
      endcase
      return descriptor(idx, len, start);
   endfunction

   function automatic awcr_item_type noise_item();
      awcr_item_type it;
      it = column({$urandom, $urandom}, 8'($urandom), $urandom_range(3) == 0);
      it.cmd = 1'($urandom);
      it.sample_index = 3'($urandom);
      it.sample_length = 24'($urandom);
      it.start_hint = 24'($urandom);
      return it;
   endfunction

   // called just after a falling edge; returns just after a falling edge
   task automatic send_item(input awcr_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= it.cmd;
      req_sample_index <= it.sample_index;
      req_sample_length <= it.sample_length;
      req_start_hint <= it.start_hint;
      req_column_bytes <= it.column_bytes;
      req_column_masks <= it.column_masks;
      req_last_column <= it.last_column;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      runs.note_item(it);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      runs.note_config(idx, value);
      @(negedge clock);
   endtask

   task automatic configure(input int count, input int bound, input int span);
      put_reg(CSR_SAMPLE_COUNT, CSR_DATA_BITS'(count));
      put_reg(CSR_LOWER_BOUND, CSR_DATA_BITS'(bound));
      put_reg(CSR_REACH, CSR_DATA_BITS'(span));
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (runs.pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // descriptors, then a window of columns closed by a last column
   task automatic run_search();
      int lanes;
      int n_desc;
      int n_cols;
      int hit_pct;
      lanes = runs.lanes_used();
      n_desc = $urandom_range(lanes);
      for (int k = 0; k < n_desc; k++) send_item(random_descriptor(lanes));
      n_cols = $urandom_range(1, 14);
      hit_pct = $urandom_range(30, 95);
      for (int k = 0; k < n_cols; k++) begin
         if ($urandom_range(19) == 0) send_item(random_descriptor(lanes));
         send_item(random_column(lanes, $urandom_range(99) < hit_pct, k == n_cols - 1));
      end
   endtask

   task automatic run_phase(input int count, input int bound, input int span,
                            input int idle, input int stall, input int n_items);
      int target;
      configure(count, bound, span);
      send_idle_pct = idle;
      stall_pct = stall;
      target = items_sent + n_items;
      while (items_sent < target) begin
         if ($urandom_range(99) < 85) run_search();
         else send_item(noise_item());
      end
      req_valid <= 1'b0;
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // two lanes in use, reset registers; every anchor gets written here
      send_item(descriptor(3'd0, 24'd100, 24'd40));
      send_item(descriptor(3'd1, 24'hFFFFFF, 24'hFFFFFE));
      send_item(descriptor(3'd1, 24'd5000, 24'd3000));
      send_item(column(64'h0, 8'h00, 1'b0));
      send_item(column(64'h0, 8'h00, 1'b0));
      send_item(column(64'h0000_0000_0000_5A00, 8'h00, 1'b0));
      send_item(column(64'h1111_1111_1111_1111, 8'h20, 1'b0));
      send_item(column(64'h0, 8'h01, 1'b0));
      send_item(descriptor(3'd7, 24'd30, 24'd29));
      send_item(column('1, 8'hFC, 1'b0));
      send_item(column(64'h0000_0000_0000_ABAB, 8'h00, 1'b1));
      send_item(descriptor(3'd2, 24'd0, 24'd5));
      send_item(descriptor(3'd3, 24'hFFFFFF, 24'hFFFFFF));
      send_item(descriptor(3'd4, 24'd1, 24'd0));
      send_item(descriptor(3'd5, 24'd20, 24'd3));
      send_item(descriptor(3'd6, 24'd40000, 24'd39000));
      send_item(column('1, 8'hFF, 1'b1));
      // no descriptors: full reach, positions wrap below zero
      send_item(column(64'h0000_0000_0000_7E7E, 8'h00, 1'b0));
      send_item(column(64'h0000_0000_0000_7E7E, 8'h00, 1'b0));
      send_item(column(64'h0000_0000_0000_7E7E, 8'h00, 1'b1));
      req_valid <= 1'b0;
      drain();

      long_hold = 1'b1;
      run_phase(8, 0, 65535, 0, 0, 60);
      run_phase(0, 1, 0, 51, 0, 60);
      run_phase(15, 131071, 10000, 0, 51, 50);
      run_phase(1, 0, $urandom_range(65535), 30, 30, 60);
      run_phase($urandom_range(1, 8), $urandom_range(3), $urandom_range(65535), 51, 0, 60);
      run_phase($urandom_range(15), $urandom_range(6), $urandom_range(200), 0, 51, 60);
      run_phase(3, 2, 65535, 30, 30, 40);

      runs.errors += runs.pending_results.size();
      $display("Run covered %0d items: %0d window reports, %0d match results, %0d empty outcomes",
               items_sent, runs.window_reports, runs.match_results, runs.empty_outcomes);
      $display("Checked %0d results over %0d cycles, %0d mismatches",
               runs.compared, cycles, runs.errors);
      if (runs.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
